// ----- design/stk_pkg.sv -----
// Shared types, token codes and character classes for the script tokenizer.
// Used by stk_lex_core, stk_result_fifo and script_tokenizer_top. No dependencies.

package stk_pkg;

   typedef logic [5:0] code_type;

   // Token codes
   localparam code_type TOK_UNKNOWN = 6'd0;
   localparam code_type TOK_PLUS    = 6'd1;
   localparam code_type TOK_MINUS   = 6'd2;
   localparam code_type TOK_STAR    = 6'd3;
   localparam code_type TOK_SLASH   = 6'd4;
   localparam code_type TOK_AMP     = 6'd5;
   localparam code_type TOK_BAR     = 6'd6;
   localparam code_type TOK_CARET   = 6'd7;
   localparam code_type TOK_BANG    = 6'd8;
   localparam code_type TOK_GT      = 6'd9;
   localparam code_type TOK_LT      = 6'd10;
   localparam code_type TOK_ASSIGN  = 6'd11;
   localparam code_type TOK_LPAREN  = 6'd12;
   localparam code_type TOK_RPAREN  = 6'd13;
   localparam code_type TOK_LBRACK  = 6'd14;
   localparam code_type TOK_RBRACK  = 6'd15;
   localparam code_type TOK_LBRACE  = 6'd16;
   localparam code_type TOK_RBRACE  = 6'd17;
   localparam code_type TOK_SEMI    = 6'd18;
   localparam code_type TOK_IF      = 6'd19;
   localparam code_type TOK_JUMP    = 6'd20;
   localparam code_type TOK_RETURN  = 6'd21;
   localparam code_type TOK_CALL    = 6'd22;
   localparam code_type TOK_PARAM   = 6'd23;
   localparam code_type TOK_INC     = 6'd24;
   localparam code_type TOK_DEC     = 6'd25;
   localparam code_type TOK_ADD_EQ  = 6'd26;
   localparam code_type TOK_SUB_EQ  = 6'd27;
   localparam code_type TOK_MUL_EQ  = 6'd28;
   localparam code_type TOK_DIV_EQ  = 6'd29;
   localparam code_type TOK_AND_EQ  = 6'd30;
   localparam code_type TOK_OR_EQ   = 6'd31;
   localparam code_type TOK_XOR_EQ  = 6'd32;
   localparam code_type TOK_NE      = 6'd33;
   localparam code_type TOK_GE      = 6'd34;
   localparam code_type TOK_LE      = 6'd35;
   localparam code_type TOK_EQ      = 6'd36;
   localparam code_type TOK_NUM     = 6'd37;
   localparam code_type TOK_WORD    = 6'd38;
   localparam code_type TOK_CODE    = 6'd39;
   localparam code_type TOK_EOF     = 6'd40;
   localparam code_type TOK_ERR     = 6'd41;

   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_AT         = 8'h40;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DASH       = 8'h2D;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = 3;
   localparam int CNT_W      = 4;
   localparam int SLOTS      = 3;

   typedef struct packed {
      code_type    token_type;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        last_token;
   } stk_token_type;

   // Up to three results produced by one item, in order, slot 0 first
   typedef struct packed {
      logic [SLOTS-1:0]                valid;
      stk_token_type [SLOTS-1:0]       tok;
   } stk_burst_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == CHAR_UNDERSCORE);
   endfunction

   function automatic logic is_wordc(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CHAR_DASH);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   function automatic code_type op_single(input logic [7:0] c);
      code_type t;
      case (c)
         "+":     t = TOK_PLUS;
         "-":     t = TOK_MINUS;
         "*":     t = TOK_STAR;
         "/":     t = TOK_SLASH;
         "&":     t = TOK_AMP;
         "|":     t = TOK_BAR;
         "^":     t = TOK_CARET;
         "!":     t = TOK_BANG;
         ">":     t = TOK_GT;
         "<":     t = TOK_LT;
         "=":     t = TOK_ASSIGN;
         default: t = TOK_UNKNOWN;
      endcase
      return t;
   endfunction

   function automatic code_type op_pair(input logic [7:0] a, input logic [7:0] b);
      code_type t;
      t = TOK_UNKNOWN;
      case (a)
         "+": if (b == "=") t = TOK_ADD_EQ; else if (b == "+") t = TOK_INC;
         "-": if (b == "=") t = TOK_SUB_EQ; else if (b == "-") t = TOK_DEC;
         "*": if (b == "=") t = TOK_MUL_EQ;
         "/": if (b == "=") t = TOK_DIV_EQ;
         "&": if (b == "=") t = TOK_AND_EQ;
         "|": if (b == "=") t = TOK_OR_EQ;
         "^": if (b == "=") t = TOK_XOR_EQ;
         "!": if (b == "=") t = TOK_NE;
         "=": if (b == "=") t = TOK_EQ;
         ">": if (b == "=") t = TOK_GE; else if (b == "<") t = TOK_NE;
         "<": if (b == "=") t = TOK_LE; else if (b == ">") t = TOK_NE;
         default: t = TOK_UNKNOWN;
      endcase
      return t;
   endfunction

   function automatic code_type bracket_type(input logic [7:0] c);
      code_type t;
      case (c)
         "(":     t = TOK_LPAREN;
         ")":     t = TOK_RPAREN;
         "[":     t = TOK_LBRACK;
         "]":     t = TOK_RBRACK;
         "{":     t = TOK_LBRACE;
         "}":     t = TOK_RBRACE;
         ";":     t = TOK_SEMI;
         default: t = TOK_UNKNOWN;
      endcase
      return t;
   endfunction

   // Keyword match on the count and the first (up to six) characters
   function automatic code_type word_type(input logic [15:0] cnt, input logic [47:0] win);
      code_type t;
      if ((cnt == 16'd2) && (win == 48'("if")))
         t = TOK_IF;
      else if ((cnt == 16'd4) && (win == 48'("jump")))
         t = TOK_JUMP;
      else if ((cnt == 16'd6) && (win == 48'("return")))
         t = TOK_RETURN;
      else if ((cnt == 16'd4) && (win == 48'("call")))
         t = TOK_CALL;
      else if ((cnt == 16'd5) && (win == 48'("param")))
         t = TOK_PARAM;
      else
         t = TOK_WORD;
      return t;
   endfunction

endpackage

// ----- design/stk_lex_core.sv -----
// Lexer core: input register, lexer state and the per-byte step logic.
// Produces up to three tokens per byte as a stk_pkg::stk_burst_type.

module stk_lex_core #(
   parameter longint unsigned TEXT_POSITIONS = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic                  req_last_char,
   input  logic                  room_ok,
   output stk_pkg::stk_burst_type burst
);

   localparam int POS_W = $clog2(TEXT_POSITIONS);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(TEXT_POSITIONS - 64'd1);
   localparam int SLOTS_L = stk_pkg::SLOTS;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_OP   = 3'd1;
   localparam logic [2:0] M_NUM  = 3'd2;
   localparam logic [2:0] M_WORD = 3'd3;
   localparam logic [2:0] M_CODE = 3'd4;
   localparam logic [2:0] M_ERR  = 3'd5;

   logic             stg_valid_ff;
   logic [7:0]       stg_char_ff;
   logic             stg_last_ff;
   logic             fire;

   logic [2:0]       mode_ff, mode_in;
   logic [7:0]       pend_ff, pend_in;
   logic [POS_W-1:0] tb_ff, tb_in;
   logic [15:0]      tc_ff, tc_in;
   logic [47:0]      kw_ff, kw_in;
   logic             als_ff, als_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [SLOTS_L-1:0] slot_v;
   stk_pkg::stk_token_type tok0, tok1, tok2;
   stk_pkg::code_type pair, single_c, brk_c;
   logic [7:0] c;
   logic fresh, hold;

   function automatic logic [15:0] sat_pos(input logic [POS_W-1:0] p);
      logic [POS_W+15:0] wide;
      wide = (POS_W+16)'(p);
      return (wide > (POS_W+16)'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
   endfunction

   function automatic stk_pkg::stk_token_type mk(input stk_pkg::code_type t,
                                                input logic [15:0] s,
                                                input logic [15:0] l,
                                                input logic e);
      stk_pkg::stk_token_type r;
      r.token_type   = t;
      r.token_start  = s;
      r.token_length = l;
      r.last_token   = e;
      return r;
   endfunction

   function automatic logic [15:0] grow_count(input logic [15:0] n);
      return (n < 16'hFFFF) ? n + 16'd1 : n;
   endfunction

   function automatic logic [47:0] grow_window(input logic [15:0] n, input logic [47:0] w,
                                               input logic [7:0] ch);
      return (n < 16'd6) ? {w[39:0], ch} : w;
   endfunction

   assign fire      = stg_valid_ff && room_ok;
   assign req_ready = !stg_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stg_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         stg_char_ff <= req_char_code;
         stg_last_ff <= req_last_char;
      end
   end

   assign c        = stg_char_ff;
   assign pair     = stk_pkg::op_pair(pend_ff, c);
   assign single_c = stk_pkg::op_single(c);
   assign brk_c    = stk_pkg::bracket_type(c);

   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      tb_in   = tb_ff;
      tc_in   = tc_ff;
      kw_in   = kw_ff;
      als_in  = als_ff;
      pos_in  = pos_ff;
      slot_v  = '0;
      tok0    = '0;
      tok1    = '0;
      tok2    = '0;
      fresh   = 1'b1;
      hold    = 1'b0;

      // Continue or close the token in progress
      unique case (mode_ff)
         M_ERR: begin
            fresh = 1'b0;
            hold  = 1'b1;
         end
         M_OP: begin
            slot_v[0] = 1'b1;
            if (pair != stk_pkg::TOK_UNKNOWN) begin
               tok0  = mk(pair, sat_pos(tb_ff), 16'd2, 1'b0);
               fresh = 1'b0;
            end else begin
               tok0 = mk(stk_pkg::op_single(pend_ff), sat_pos(tb_ff), 16'd1, 1'b0);
            end
            mode_in = M_IDLE;
         end
         M_NUM: begin
            if (stk_pkg::is_digit(c)) begin
               tc_in = grow_count(tc_ff);
               kw_in = grow_window(tc_ff, kw_ff, c);
               fresh = 1'b0;
            end else begin
               slot_v[0] = 1'b1;
               tok0      = mk(stk_pkg::TOK_NUM, sat_pos(tb_ff), tc_ff, 1'b0);
               mode_in   = M_IDLE;
            end
         end
         M_WORD: begin
            if (stk_pkg::is_wordc(c)) begin
               tc_in = grow_count(tc_ff);
               kw_in = grow_window(tc_ff, kw_ff, c);
               fresh = 1'b0;
            end else begin
               slot_v[0] = 1'b1;
               tok0      = mk(stk_pkg::word_type(tc_ff, kw_ff), sat_pos(tb_ff), tc_ff, 1'b0);
               mode_in   = M_IDLE;
            end
         end
         M_CODE: begin
            if (stk_pkg::is_eol(c)) begin
               slot_v[0] = 1'b1;
               tok0      = mk(stk_pkg::TOK_CODE, sat_pos(tb_ff), tc_ff, 1'b0);
               mode_in   = M_IDLE;
            end else begin
               tc_in = grow_count(tc_ff);
               kw_in = grow_window(tc_ff, kw_ff, c);
            end
            fresh = 1'b0;
         end
         default: begin
            mode_in = M_IDLE;
         end
      endcase

      // Start a new token on this byte
      if (fresh && !stk_pkg::is_space(c)) begin
         if (single_c != stk_pkg::TOK_UNKNOWN) begin
            mode_in = M_OP;
            pend_in = c;
            tb_in   = pos_ff;
            tc_in   = 16'd1;
            kw_in   = {40'd0, c};
         end else if (brk_c != stk_pkg::TOK_UNKNOWN) begin
            slot_v[1] = 1'b1;
            tok1      = mk(brk_c, sat_pos(pos_ff), 16'd1, 1'b0);
         end else if (c == stk_pkg::CHAR_AT) begin
            if (als_ff) begin
               mode_in = M_CODE;
               tb_in   = pos_ff;
               tc_in   = 16'd1;
               kw_in   = {40'd0, c};
            end else begin
               // misplaced '@': error ends the text, rest of input is dropped
               slot_v[1] = 1'b1;
               tok1      = mk(stk_pkg::TOK_ERR, sat_pos(pos_ff), 16'd1, 1'b1);
               mode_in   = M_ERR;
               hold      = 1'b1;
            end
         end else if (stk_pkg::is_digit(c)) begin
            mode_in = M_NUM;
            tb_in   = pos_ff;
            tc_in   = 16'd1;
            kw_in   = {40'd0, c};
         end else if (stk_pkg::is_alpha(c)) begin
            mode_in = M_WORD;
            tb_in   = pos_ff;
            tc_in   = 16'd1;
            kw_in   = {40'd0, c};
         end else begin
            slot_v[1] = 1'b1;
            tok1      = mk(stk_pkg::TOK_UNKNOWN, sat_pos(pos_ff), 16'd0, 1'b0);
         end
      end

      if (!hold) begin
         als_in = stk_pkg::is_eol(c);
         pos_in = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
      end

      if (stg_last_ff) begin
         if (!hold) begin
            // flush whatever is pending, then EOF; slot 1 is free here
            unique case (mode_in)
               M_OP: begin
                  slot_v[1] = 1'b1;
                  tok1 = mk(stk_pkg::op_single(pend_in), sat_pos(tb_in), 16'd1, 1'b0);
               end
               M_NUM: begin
                  slot_v[1] = 1'b1;
                  tok1 = mk(stk_pkg::TOK_NUM, sat_pos(tb_in), tc_in, 1'b0);
               end
               M_WORD: begin
                  slot_v[1] = 1'b1;
                  tok1 = mk(stk_pkg::word_type(tc_in, kw_in), sat_pos(tb_in), tc_in, 1'b0);
               end
               M_CODE: begin
                  slot_v[1] = 1'b1;
                  tok1 = mk(stk_pkg::TOK_CODE, sat_pos(tb_in), tc_in, 1'b0);
               end
               default: begin
               end
            endcase
            slot_v[2] = 1'b1;
            tok2      = mk(stk_pkg::TOK_EOF, 16'd0, 16'd0, 1'b1);
         end
         mode_in = M_IDLE;
         pend_in = '0;
         tb_in   = '0;
         tc_in   = '0;
         kw_in   = '0;
         als_in  = 1'b1;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pend_ff <= '0;
         tb_ff   <= '0;
         tc_ff   <= '0;
         kw_ff   <= '0;
         als_ff  <= 1'b1;
         pos_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         tb_ff   <= tb_in;
         tc_ff   <= tc_in;
         kw_ff   <= kw_in;
         als_ff  <= als_in;
         pos_ff  <= pos_in;
      end
   end

   assign burst.valid = slot_v & {SLOTS_L{fire}};
   assign burst.tok   = {tok2, tok1, tok0};

   a_err_silent : assert property (@(posedge clock) disable iff (reset)
      fire && (mode_ff == M_ERR) |-> (burst.valid == '0))
      else $error("tokens produced while discarding after an error");

   a_last_resets : assert property (@(posedge clock) disable iff (reset)
      fire && stg_last_ff |=> (mode_ff == M_IDLE) && (pos_ff == '0) && als_ff)
      else $error("state not back to start after the final byte");

   a_eof_on_last : assert property (@(posedge clock) disable iff (reset)
      burst.valid[2] |-> stg_last_ff && !burst.valid[0] || stg_last_ff)
      else $error("EOF produced without the final byte");

   a_err_stops : assert property (@(posedge clock) disable iff (reset)
      fire && burst.valid[1] && (burst.tok[1].token_type == stk_pkg::TOK_ERR)
      |-> !burst.valid[2])
      else $error("EOF follows an error token");

endmodule

// ----- design/stk_result_fifo.sv -----
// Result queue: takes up to three tokens per cycle, delivers one per transfer.
// Depends on stk_pkg for the token and burst types.

module stk_result_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  stk_pkg::stk_burst_type burst,
   output logic                   room_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stk_pkg::stk_token_type rsp_tok
);

   localparam int PW = stk_pkg::PTR_W;
   localparam int CW = stk_pkg::CNT_W;

   stk_pkg::stk_token_type entry_ff [stk_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    push_n;
   logic [PW-1:0] off1, off2;
   logic          pop;

   assign push_n  = 2'(burst.valid[0]) + 2'(burst.valid[1]) + 2'(burst.valid[2]);
   assign off1    = PW'(burst.valid[0]);
   assign off2    = PW'(burst.valid[0]) + PW'(burst.valid[1]);
   assign pop     = rsp_valid && rsp_ready;
   assign room_ok = count_ff <= CW'(stk_pkg::FIFO_DEPTH - stk_pkg::SLOTS);

   assign rsp_valid = count_ff != '0;
   assign rsp_tok   = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push_n) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slots are packed in order behind the write pointer
   always_ff @(posedge clock) begin
      if (burst.valid[0]) entry_ff[wr_ptr_ff] <= burst.tok[0];
      if (burst.valid[1]) entry_ff[wr_ptr_ff + off1] <= burst.tok[1];
      if (burst.valid[2]) entry_ff[wr_ptr_ff + off2] <= burst.tok[2];
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(stk_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      (burst.valid != '0) |-> room_ok)
      else $error("tokens pushed without room for a full burst");

   a_pop_only : assert property (@(posedge clock) disable iff (reset)
      pop && (burst.valid == '0) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("queue count wrong after a lone transfer");

endmodule

// ----- design/script_tokenizer_top.sv -----
// Flow: a byte accepted on req_ sits in the input register, is lexed into the result queue
// once the queue has room, and its tokens show on rsp_ after those already queued.
// Throughput: one byte per cycle while the 8-entry result queue has room for three
// tokens; the queue drains one token per rsp_ transfer, so a byte that yields more
// than one token can hold req_ready low until the consumer catches up.
// Reset: synchronous, active high; clears lexer state and the queue.

module script_tokenizer_top #(
   parameter longint unsigned TEXT_POSITIONS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_type,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_token
);

   stk_pkg::stk_burst_type burst;
   stk_pkg::stk_token_type rsp_tok;
   logic                   room_ok;

   stk_lex_core #(
      .TEXT_POSITIONS(TEXT_POSITIONS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .room_ok       (room_ok),
      .burst         (burst)
   );

   stk_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .burst     (burst),
      .room_ok   (room_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_tok   (rsp_tok)
   );

   assign rsp_token_type   = rsp_tok.token_type;
   assign rsp_token_start  = rsp_tok.token_start;
   assign rsp_token_length = rsp_tok.token_length;
   assign rsp_last_token   = rsp_tok.last_token;

endmodule

// ----- tb/sv/tb_script_tokenizer_checker.sv -----
// Token checker for script_tokenizer_top: watches req_/rsp_ transfers, predicts the
// token stream of each accepted byte and compares every rsp_ transfer in order.
// Depends on stk_pkg for the token codes and character constants.

module tb_script_tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [5:0]  rsp_token_type,
   input  logic [15:0] rsp_token_start,
   input  logic [15:0] rsp_token_length,
   input  logic        rsp_last_token,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);

   localparam logic [2:0] LEX_IDLE = 3'd0;
   localparam logic [2:0] LEX_OP   = 3'd1;
   localparam logic [2:0] LEX_NUM  = 3'd2;
   localparam logic [2:0] LEX_WORD = 3'd3;
   localparam logic [2:0] LEX_CODE = 3'd4;
   localparam logic [2:0] LEX_SKIP = 3'd5;

   typedef struct packed {
      stk_pkg::code_type kind;
      logic [15:0]       start;
      logic [15:0]       len;
      logic              last;
   } lex_token_type;

   localparam int PRINT_CAP = 100;

   lex_token_type expected_tokens[$];
   logic [2:0]  lex_mode;
   logic [7:0]  pend_char;
   logic [15:0] tok_begin;
   logic [15:0] tok_count;
   logic [15:0] text_pos;
   logic [47:0] kw_window;
   logic        line_start;
   int          fail_tally = 0;
   int          checked = 0;

   function automatic logic cls_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic cls_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == stk_pkg::CHAR_UNDERSCORE;
   endfunction

   function automatic logic cls_eol(input logic [7:0] c);
      return c == stk_pkg::CHAR_CR || c == stk_pkg::CHAR_LF;
   endfunction

   function automatic logic cls_blank(input logic [7:0] c);
      return cls_eol(c) || c == stk_pkg::CHAR_SPACE || c == stk_pkg::CHAR_TAB;
   endfunction

   function automatic stk_pkg::code_type single_op(input logic [7:0] c);
      case (c)
         "+": return stk_pkg::TOK_PLUS;
         "-": return stk_pkg::TOK_MINUS;
         "*": return stk_pkg::TOK_STAR;
         "/": return stk_pkg::TOK_SLASH;
         "&": return stk_pkg::TOK_AMP;
         "|": return stk_pkg::TOK_BAR;
         "^": return stk_pkg::TOK_CARET;
         "!": return stk_pkg::TOK_BANG;
         ">": return stk_pkg::TOK_GT;
         "<": return stk_pkg::TOK_LT;
         "=": return stk_pkg::TOK_ASSIGN;
         default: return stk_pkg::TOK_UNKNOWN;
      endcase
   endfunction

   // second character decides; anything not listed means no pair
   function automatic stk_pkg::code_type pair_op(input logic [7:0] a, input logic [7:0] b);
      stk_pkg::code_type t;
      t = stk_pkg::TOK_UNKNOWN;
      if (b == "=") begin
         case (a)
            "+": t = stk_pkg::TOK_ADD_EQ;
            "-": t = stk_pkg::TOK_SUB_EQ;
            "*": t = stk_pkg::TOK_MUL_EQ;
            "/": t = stk_pkg::TOK_DIV_EQ;
            "&": t = stk_pkg::TOK_AND_EQ;
            "|": t = stk_pkg::TOK_OR_EQ;
            "^": t = stk_pkg::TOK_XOR_EQ;
            "!": t = stk_pkg::TOK_NE;
            "=": t = stk_pkg::TOK_EQ;
            ">": t = stk_pkg::TOK_GE;
            "<": t = stk_pkg::TOK_LE;
            default: t = stk_pkg::TOK_UNKNOWN;
         endcase
      end else if (a == "+" && b == "+") begin
         t = stk_pkg::TOK_INC;
      end else if (a == "-" && b == "-") begin
         t = stk_pkg::TOK_DEC;
      end else if ((a == ">" && b == "<") || (a == "<" && b == ">")) begin
         t = stk_pkg::TOK_NE;
      end
      return t;
   endfunction

   function automatic stk_pkg::code_type bracket_code(input logic [7:0] c);
      case (c)
         "(": return stk_pkg::TOK_LPAREN;
         ")": return stk_pkg::TOK_RPAREN;
         "[": return stk_pkg::TOK_LBRACK;
         "]": return stk_pkg::TOK_RBRACK;
         "{": return stk_pkg::TOK_LBRACE;
         "}": return stk_pkg::TOK_RBRACE;
         ";": return stk_pkg::TOK_SEMI;
         default: return stk_pkg::TOK_UNKNOWN;
      endcase
   endfunction

   // window holds the first six characters of the word, oldest in the high byte
   function automatic stk_pkg::code_type word_code();
      if (tok_count == 16'd2 && kw_window == {32'd0, "if"}) return stk_pkg::TOK_IF;
      if (tok_count == 16'd4 && kw_window == {16'd0, "jump"}) return stk_pkg::TOK_JUMP;
      if (tok_count == 16'd6 && kw_window == "return") return stk_pkg::TOK_RETURN;
      if (tok_count == 16'd4 && kw_window == {16'd0, "call"}) return stk_pkg::TOK_CALL;
      if (tok_count == 16'd5 && kw_window == {8'd0, "param"}) return stk_pkg::TOK_PARAM;
      return stk_pkg::TOK_WORD;
   endfunction

   task automatic push_token(input stk_pkg::code_type kind, input logic [15:0] start,
                             input logic [15:0] len, input logic last);
      lex_token_type tok;
      tok.kind  = kind;
      tok.start = start;
      tok.len   = len;
      tok.last  = last;
      expected_tokens.push_back(tok);
   endtask

   task automatic clear_lexer();
      lex_mode   = LEX_IDLE;
      pend_char  = 8'd0;
      tok_begin  = 16'd0;
      tok_count  = 16'd0;
      text_pos   = 16'd0;
      kw_window  = 48'd0;
      line_start = 1'b1;
   endtask

   task automatic grow_token(input logic [7:0] c);
      if (tok_count < 16'd6) kw_window = {kw_window[39:0], c};
      if (tok_count != 16'hFFFF) tok_count++;
   endtask

   task automatic open_token(input logic [2:0] mode, input logic [7:0] c);
      lex_mode  = mode;
      tok_begin = text_pos;
      tok_count = 16'd0;
      kw_window = 48'd0;
      grow_token(c);
   endtask

   task automatic close_token();
      case (lex_mode)
         LEX_OP:   push_token(single_op(pend_char), tok_begin, 16'd1, 1'b0);
         LEX_NUM:  push_token(stk_pkg::TOK_NUM, tok_begin, tok_count, 1'b0);
         LEX_WORD: push_token(word_code(), tok_begin, tok_count, 1'b0);
         LEX_CODE: push_token(stk_pkg::TOK_CODE, tok_begin, tok_count, 1'b0);
         default: ;
      endcase
      lex_mode = LEX_IDLE;
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic last);
      logic              fresh;
      stk_pkg::code_type t;
      fresh = 1'b1;
      if (lex_mode == LEX_SKIP) begin
         // after a stray '@' everything up to and including the final byte is dropped
         if (last) clear_lexer();
      end else begin
         case (lex_mode)
            LEX_OP: begin
               t = pair_op(pend_char, c);
               if (t != stk_pkg::TOK_UNKNOWN) begin
                  push_token(t, tok_begin, 16'd2, 1'b0);
                  lex_mode = LEX_IDLE;
                  fresh = 1'b0;
               end else begin
                  close_token();
               end
            end
            LEX_NUM: begin
               if (cls_digit(c)) begin
                  grow_token(c);
                  fresh = 1'b0;
               end else begin
                  close_token();
               end
            end
            LEX_WORD: begin
               if (cls_letter(c) || cls_digit(c) || c == stk_pkg::CHAR_DASH) begin
                  grow_token(c);
                  fresh = 1'b0;
               end else begin
                  close_token();
               end
            end
            LEX_CODE: begin
               // the CR/LF ending a code point is consumed
               if (cls_eol(c)) close_token();
               else grow_token(c);
               fresh = 1'b0;
            end
            default: lex_mode = LEX_IDLE;
         endcase

         if (fresh && c == stk_pkg::CHAR_AT && !line_start) begin
            push_token(stk_pkg::TOK_ERR, text_pos, 16'd1, 1'b1);
            if (last) clear_lexer();
            else lex_mode = LEX_SKIP;
         end else begin
            if (fresh && !cls_blank(c)) begin
               if (single_op(c) != stk_pkg::TOK_UNKNOWN) begin
                  open_token(LEX_OP, c);
                  pend_char = c;
               end else if (bracket_code(c) != stk_pkg::TOK_UNKNOWN) begin
                  push_token(bracket_code(c), text_pos, 16'd1, 1'b0);
               end else if (c == stk_pkg::CHAR_AT) begin
                  open_token(LEX_CODE, c);
               end else if (cls_digit(c)) begin
                  open_token(LEX_NUM, c);
               end else if (cls_letter(c)) begin
                  open_token(LEX_WORD, c);
               end else begin
                  push_token(stk_pkg::TOK_UNKNOWN, text_pos, 16'd0, 1'b0);
               end
            end
            line_start = cls_eol(c);
            if (text_pos != 16'hFFFF) text_pos++;
            if (last) begin
               close_token();
               push_token(stk_pkg::TOK_EOF, 16'd0, 16'd0, 1'b1);
               clear_lexer();
            end
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      fail_tally++;
      if (fail_tally <= PRINT_CAP) $display("checker: %s", msg);
   endtask

   always @(posedge clock) begin
      lex_token_type got;
      lex_token_type want;
      if (reset) begin
         clear_lexer();
         expected_tokens.delete();
      end else begin
         // results first: a byte accepted at this edge cannot have a token out yet
         if (rsp_valid && rsp_ready) begin
            got.kind  = rsp_token_type;
            got.start = rsp_token_start;
            got.len   = rsp_token_length;
            got.last  = rsp_last_token;
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("unexpected token type %0d start %0d len %0d last %0d",
                  got.kind, got.start, got.len, got.last));
            end else begin
               want = expected_tokens.pop_front();
               checked++;
               if (got !== want)
                  report_mismatch($sformatf(
                     "token %0d: got type %0d start %0d len %0d last %0d, want %0d %0d %0d %0d",
                     checked, got.kind, got.start, got.len, got.last,
                     want.kind, want.start, want.len, want.last));
            end
         end
         if (req_valid && req_ready) predict_tokens(req_char_code, req_last_char);
      end
      fail_count    <= fail_tally;
      pending_count <= expected_tokens.size();
      checked_count <= checked;
   end

endmodule

// ----- tb/sv/tb_script_tokenizer_top.sv -----
// Testbench top for script_tokenizer_top: clock, reset, byte stimulus with bursts and
// gaps, a stalling token sink, and the verdict. Needs stk_pkg and
// tb_script_tokenizer_checker.

module tb_script_tokenizer_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEM_TARGET  = 310;
   localparam int HOLD_CYCLES  = 300;

   typedef enum int {
      FRAG_KEYWORD, FRAG_NEAR_KEYWORD, FRAG_IDENT, FRAG_NUMBER, FRAG_OP, FRAG_OP_PAIR,
      FRAG_BRACKET, FRAG_BLANK, FRAG_CODE_LINE, FRAG_NOISE
   } frag_kind_type;

   typedef enum int { RX_READY, RX_COIN, RX_SPARSE, RX_TOGGLE } rx_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'd0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_token_type;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_last_token;

   int fail_count;
   int pending_count;
   int checked_count;

   logic [7:0]   text_q[$];
   int           bytes_sent = 0;
   int           text_count = 0;
   int           burst_left = 0;
   bit           gaps_on = 1'b1;
   bit           hold_req = 1'b0;
   int           cycle_count = 0;
   int           hold_cycles;
   int           style_left = 0;
   rx_style_type rx_style = RX_READY;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   script_tokenizer_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_type  (rsp_token_type),
      .rsp_token_start (rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_last_token  (rsp_last_token)
   );

   tb_script_tokenizer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_type  (rsp_token_type),
      .rsp_token_start (rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_last_token  (rsp_last_token),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count)
   );

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // token sink: switches between random stall styles, or holds off on request
   always begin : token_sink
      @(negedge clock);
      if (hold_req) begin
         rsp_ready <= 1'b0;
         for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) @(negedge clock);
         hold_req = 1'b0;
      end else begin
         if (style_left == 0) begin
            rx_style   = rx_style_type'($urandom_range(RX_READY, RX_TOGGLE));
            style_left = $urandom_range(8, 64);
         end
         style_left--;
         case (rx_style)
            RX_READY:  rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   task automatic idle_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] c, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (gaps_on && $urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
      text_count++;
   endtask

   function automatic string keyword_text(input int k);
      case (k)
         0: return "if";
         1: return "jump";
         2: return "return";
         3: return "call";
         default: return "param";
      endcase
   endfunction

   function automatic string near_keyword_text(input int k);
      case (k)
         0: return "iff";
         1: return "i";
         2: return "jum";
         3: return "jumps";
         4: return "retur";
         5: return "return_";
         6: return "Call";
         7: return "cal";
         8: return "params";
         9: return "if-";
         default: return "call9";
      endcase
   endfunction

   function automatic string op_pair_text(input int k);
      case (k)
         0: return "++";
         1: return "--";
         2: return "+=";
         3: return "-=";
         4: return "*=";
         5: return "/=";
         6: return "&=";
         7: return "|=";
         8: return "^=";
         9: return "!=";
         10: return "<>";
         11: return "><";
         12: return ">=";
         13: return "<=";
         default: return "==";
      endcase
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return stk_pkg::CHAR_UNDERSCORE;
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(0, 3))
         0: return stk_pkg::CHAR_SPACE;
         1: return stk_pkg::CHAR_TAB;
         2: return stk_pkg::CHAR_CR;
         default: return stk_pkg::CHAR_LF;
      endcase
   endfunction

   task automatic add_fragment();
      string         ops;
      string         brackets;
      frag_kind_type kind;
      int            n;
      ops      = "+-*/&|^!<>=";
      brackets = "()[]{};";
      kind     = frag_kind_type'($urandom_range(FRAG_KEYWORD, FRAG_NOISE));
      case (kind)
         FRAG_KEYWORD:      add_str(keyword_text($urandom_range(0, 4)));
         FRAG_NEAR_KEYWORD: add_str(near_keyword_text($urandom_range(0, 10)));
         FRAG_IDENT: begin
            text_q.push_back(rand_letter());
            n = $urandom_range(0, 6);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0: text_q.push_back(8'("0" + $urandom_range(0, 9)));
                  1: text_q.push_back(stk_pkg::CHAR_DASH);
                  default: text_q.push_back(rand_letter());
               endcase
            end
         end
         FRAG_NUMBER: begin
            n = $urandom_range(1, 5);
            repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
         end
         FRAG_OP: text_q.push_back(ops[$urandom_range(0, 10)]);
         FRAG_OP_PAIR: begin
            if ($urandom_range(0, 2) != 0) begin
               add_str(op_pair_text($urandom_range(0, 14)));
            end else begin
               text_q.push_back(ops[$urandom_range(0, 10)]);
               text_q.push_back(ops[$urandom_range(0, 10)]);
            end
         end
         FRAG_BRACKET: text_q.push_back(brackets[$urandom_range(0, 6)]);
         FRAG_BLANK:   text_q.push_back(rand_blank());
         FRAG_CODE_LINE: begin
            // start of text counts as a line start, so no break is needed there
            if (text_q.size() != 0)
               text_q.push_back($urandom_range(0, 1) ? stk_pkg::CHAR_LF : stk_pkg::CHAR_CR);
            text_q.push_back(stk_pkg::CHAR_AT);
            n = $urandom_range(0, 8);
            repeat (n) text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            if ($urandom_range(0, 2) != 0)
               text_q.push_back($urandom_range(0, 1) ? stk_pkg::CHAR_LF : stk_pkg::CHAR_CR);
         end
         default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic build_random_text();
      int frags;
      int r;
      frags = $urandom_range(1, 10);
      repeat (frags) begin
         add_fragment();
         r = $urandom_range(0, 5);
         if (r == 2 || r == 3) text_q.push_back(stk_pkg::CHAR_SPACE);
         else if (r >= 4) text_q.push_back(rand_blank());
      end
      // now and then a stray '@' somewhere past the start
      if ($urandom_range(0, 9) == 0)
         text_q.insert($urandom_range(1, text_q.size()), stk_pkg::CHAR_AT);
   endtask

   initial begin : stimulus
      string dense;
      bit    pressure_done;
      dense         = "();[]{}+;(x)9;";
      pressure_done = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // code point at start of text, then an operator cut off by the end
      add_str("@k");
      text_q.push_back(stk_pkg::CHAR_CR);
      add_str("x+");
      send_text();
      // byte extremes and unknown bytes
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      add_str("9");
      send_text();
      // '@' in mid-line: error, rest of text dropped
      add_str("a@zz");
      send_text();
      // lone '@' that is also the final byte
      add_str("@");
      send_text();
      add_str("if <>==");
      send_text();
      // stray '@' as the final byte
      add_str("q@");
      send_text();

      while (bytes_sent < ITEM_TARGET) begin
         if (!pressure_done && bytes_sent > 150) begin
            // sink holds off while a token-dense text fills the result queue
            pressure_done = 1'b1;
            hold_req      = 1'b1;
            gaps_on       = 1'b0;
            repeat (3) add_str(dense);
            send_text();
            gaps_on = 1'b1;
         end
         build_random_text();
         send_text();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d bytes in %0d texts, %0d tokens compared", bytes_sent,
               text_count, checked_count);
      $display("summary: code points, stray '@', odd bytes and operator pairs; %0s %0d cycles",
               "sink held off once for", HOLD_CYCLES);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/stk_pkg.sv
design/stk_lex_core.sv
design/stk_result_fifo.sv
design/script_tokenizer_top.sv
tb/sv/tb_script_tokenizer_checker.sv
tb/sv/tb_script_tokenizer_top.sv
